// ===== src/rsid_pkg.sv =====
// Shared types, constants and generator table for the RS(15,3) GF(16) encoder.
`default_nettype none
package rsid_pkg;

    localparam int SYM_W           = 4;
    localparam int CODE_W          = 12;
    localparam int NUM_SYMBOLS_DEF = 15;
    localparam int NUM_ROUNDS      = 12;
    localparam int ROUND_W         = $clog2(NUM_ROUNDS);
    localparam int MSG_SYMBOLS     = 3;

    // x^4 + x^3 + 1, low four bits, folded in on carry out of bit 3
    localparam logic [SYM_W-1:0] GF_POLY_LO = 4'h9;

    typedef struct packed {
        logic               load;
        logic               calc;
        logic               first;
        logic               emit;
        logic               last;
        logic [ROUND_W-1:0] round;
        logic [SYM_W-1:0]   pos;
    } rsid_ctrl_t;

    function automatic logic [SYM_W-1:0] gf_root(input logic [ROUND_W-1:0] idx);
        logic [SYM_W-1:0] r;
        begin
            case (idx)
                4'd0:    r = 4'd2;
                4'd1:    r = 4'd4;
                4'd2:    r = 4'd8;
                4'd3:    r = 4'd9;
                4'd4:    r = 4'd11;
                4'd5:    r = 4'd15;
                4'd6:    r = 4'd7;
                4'd7:    r = 4'd14;
                4'd8:    r = 4'd5;
                4'd9:    r = 4'd10;
                4'd10:   r = 4'd13;
                4'd11:   r = 4'd3;
                default: r = 4'd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/rsid_gf16_mul.sv =====
// GF(16) multiplier, field polynomial x^4+x^3+1.
`default_nettype none
module rsid_gf16_mul
    import rsid_pkg::*;
(
    input  wire logic [SYM_W-1:0] a,
    input  wire logic [SYM_W-1:0] b,
    output logic      [SYM_W-1:0] p
);

    logic [SYM_W-1:0] x0, x1, x2, x3;

    always_comb
    begin
        x0 = a;
        x1 = {x0[SYM_W-2:0], 1'b0} ^ (x0[SYM_W-1] ? GF_POLY_LO : '0);
        x2 = {x1[SYM_W-2:0], 1'b0} ^ (x1[SYM_W-1] ? GF_POLY_LO : '0);
        x3 = {x2[SYM_W-2:0], 1'b0} ^ (x2[SYM_W-1] ? GF_POLY_LO : '0);
        p  = (b[0] ? x0 : '0) ^ (b[1] ? x1 : '0) ^ (b[2] ? x2 : '0) ^ (b[3] ? x3 : '0);
    end

endmodule
`default_nettype wire

// ===== src/rsid_ctrl.sv =====
// Sequencer: round and symbol counters for the multiply passes and the emit pass.
`default_nettype none
module rsid_ctrl
    import rsid_pkg::*;
#(
    parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    output rsid_ctrl_t ctrl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam logic [SYM_W-1:0]   POS_LAST   = SYM_W'(NUM_SYMBOLS - 1);
    localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(NUM_ROUNDS - 1);

    logic [1:0]         state_reg, state_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [SYM_W-1:0]   pos_reg, pos_next;
    logic               accept;
    logic               pos_end;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign pos_end = (pos_reg == POS_LAST);

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        pos_next   = pos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CALC;
                    round_next = '0;
                    pos_next   = '0;
                end
            end
            ST_CALC:
            begin
                if (pos_end)
                begin
                    pos_next = '0;
                    if (round_reg == ROUND_LAST)
                    begin
                        round_next = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        round_next = round_reg + 1'b1;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (pos_end)
                begin
                    pos_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                round_next = '0;
                pos_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            pos_reg   <= pos_next;
        end
    end

    always_comb
    begin
        ctrl.load  = accept;
        ctrl.calc  = (state_reg == ST_CALC);
        ctrl.first = (pos_reg == '0);
        ctrl.emit  = (state_reg == ST_EMIT);
        ctrl.last  = (state_reg == ST_EMIT) && pos_end;
        ctrl.round = round_reg;
        ctrl.pos   = pos_reg;
    end

    a_accept_starts_calc: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_CALC && pos_reg == '0 && round_reg == '0)
        else $error("request did not start the multiply passes");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("symbol index out of range");

    a_round_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        round_reg <= ROUND_LAST)
        else $error("round index out of range");

    a_emit_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ctrl.emit) |-> $past(ctrl.calc) && $past(round_reg) == ROUND_LAST)
        else $error("emit began before the last round finished");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.last |=> !busy)
        else $error("still busy after final symbol");

endmodule
`default_nettype wire

// ===== src/rsid_reed_solomon_encoder.sv =====
// Top level: RS(15,3) GF(16) encoder with a rotating codeword line and one shared multiplier.
// Sequence: a request is loaded, twelve multiply rounds run, then the emit pass; strobes are registered.
// Symbols then come one per cycle, NUM_SYMBOLS in all, the last one flagged.
// Requests: a new one is taken only while idle, after the emit pass, as set by the single
// GF(16) multiplier, one symbol per cycle over twelve rounds, then the emit pass.
// Reset: asynchronous, active low; returns to idle, no strobe. The receiver cannot stall.
`default_nettype none
module rsid_reed_solomon_encoder
    import rsid_pkg::*;
#(
    parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [CODE_W-1:0] code,
    output logic                   busy,
    output logic                   strobe,
    output logic      [SYM_W-1:0]  symbol,
    output logic      [SYM_W-1:0]  position,
    output logic                   last
);

    rsid_ctrl_t       ctrl;
    logic [SYM_W-1:0] word_reg [NUM_SYMBOLS];
    logic [SYM_W-1:0] carry_reg;
    logic [SYM_W-1:0] prod;
    logic [SYM_W-1:0] new_sym;
    logic             strobe_reg;
    logic [SYM_W-1:0] symbol_reg;
    logic [SYM_W-1:0] position_reg;
    logic             last_reg;

    rsid_ctrl #(
        .NUM_SYMBOLS(NUM_SYMBOLS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    rsid_gf16_mul u_mul (
        .a (word_reg[0]),
        .b (gf_root(ctrl.round)),
        .p (prod)
    );

    // new c[j] = old c[j-1] ^ g*c[j]; carry holds old c[j-1]
    assign new_sym = (ctrl.first ? '0 : carry_reg) ^ prod;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int i = MSG_SYMBOLS; i < NUM_SYMBOLS; i++)
            begin
                word_reg[i] <= '0;
            end
            word_reg[0] <= code[CODE_W-1 -: SYM_W];
            word_reg[1] <= code[CODE_W-SYM_W-1 -: SYM_W];
            word_reg[2] <= code[SYM_W-1:0];
        end
        else if (ctrl.calc || ctrl.emit)
        begin
            for (int i = 0; i < NUM_SYMBOLS - 1; i++)
            begin
                word_reg[i] <= word_reg[i+1];
            end
            word_reg[NUM_SYMBOLS-1] <= ctrl.calc ? new_sym : word_reg[0];
        end
        if (ctrl.calc)
        begin
            carry_reg <= word_reg[0];
        end
        symbol_reg   <= word_reg[0];
        position_reg <= ctrl.pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= ctrl.emit;
            last_reg   <= ctrl.last;
        end
    end

    assign strobe   = strobe_reg;
    assign symbol   = symbol_reg;
    assign position = position_reg;
    assign last     = last_reg;

endmodule
`default_nettype wire

// ===== verif/tb_rsid_reed_solomon_encoder.sv =====
// Testbench for the RS(15,3) GF(16) identification encoder: directed and random codes.
`timescale 1ns / 1ps
module tb_rsid_reed_solomon_encoder;
    import rsid_pkg::*;

    localparam int NSYM        = NUM_SYMBOLS_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN       = 200;
    localparam logic [SYM_W-1:0] FOLD = 4'h9;
    localparam logic [4*NUM_ROUNDS-1:0] GEN_LIST =
        {4'd2, 4'd4, 4'd8, 4'd9, 4'd11, 4'd15, 4'd7, 4'd14, 4'd5, 4'd10, 4'd13, 4'd3};

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic [SYM_W-1:0] position;
        logic             last;
    } tone_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic [CODE_W-1:0] code;
    logic              busy;
    logic              strobe;
    logic [SYM_W-1:0]  symbol;
    logic [SYM_W-1:0]  position;
    logic              last;

    tone_t pending_tones[$];
    int    codes_sent;
    int    tones_checked;
    int    failures;
    int    cycles;
    bit    idle_on;

    rsid_reed_solomon_encoder #(
        .NUM_SYMBOLS(NSYM)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .code    (code),
        .busy    (busy),
        .strobe  (strobe),
        .symbol  (symbol),
        .position(position),
        .last    (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [SYM_W-1:0] gf16_product(input logic [SYM_W-1:0] a,
                                                      input logic [SYM_W-1:0] b);
        logic [SYM_W-1:0] acc;
        logic [SYM_W-1:0] x;
        acc = '0;
        x   = a;
        for (int k = 0; k < SYM_W; k++)
        begin
            if (b[k])
                acc ^= x;
            x = {x[SYM_W-2:0], 1'b0} ^ (x[SYM_W-1] ? FOLD : '0);
        end
        return acc;
    endfunction

    // expand one code into its codeword tones
    task automatic queue_codeword(input logic [CODE_W-1:0] c);
        logic [SYM_W-1:0] word [0:NSYM-1];
        logic [SYM_W-1:0] g;
        tone_t            t;
        for (int j = 0; j < NSYM; j++)
            word[j] = '0;
        word[0] = c[11:8];
        word[1] = c[7:4];
        word[2] = c[3:0];
        for (int r = 0; r < NUM_ROUNDS; r++)
        begin
            g = GEN_LIST[4*NUM_ROUNDS-1-4*r -: 4];
            for (int j = NSYM - 1; j > 0; j--)
                word[j] = word[j-1] ^ gf16_product(word[j], g);
            word[0] = gf16_product(word[0], g);
        end
        for (int k = 0; k < NSYM; k++)
        begin
            t.symbol   = word[k];
            t.position = SYM_W'(k);
            t.last     = (k == NSYM - 1);
            pending_tones.push_back(t);
        end
    endtask

    // one request; start stays high after acceptance until the next call decides
    task automatic send_code(input logic [CODE_W-1:0] c);
        @(negedge clk);
        if (idle_on)
        begin
            start = 1'b0;
            while (busy)
                @(negedge clk);
            // idle cycles only count while the block could take a request
            while ($urandom_range(0, 99) < 13)
            begin
                code = CODE_W'($urandom);
                @(negedge clk);
            end
        end
        start = 1'b1;
        code  = c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        queue_codeword(c);
        codes_sent++;
    endtask

    always @(posedge clk)
    begin
        tone_t exp_t;
        if (rst_n && strobe)
        begin
            if (pending_tones.size() == 0)
            begin
                $error("unexpected symbol %0h at position %0d", symbol, position);
                failures++;
            end
            else
            begin
                exp_t = pending_tones.pop_front();
                tones_checked++;
                if (symbol !== exp_t.symbol)
                begin
                    $error("symbol: expected %0h, got %0h", exp_t.symbol, symbol);
                    failures++;
                end
                if (position !== exp_t.position)
                begin
                    $error("position: expected %0d, got %0d", exp_t.position, position);
                    failures++;
                end
                if (last !== exp_t.last)
                begin
                    $error("last: expected %0b, got %0b", exp_t.last, last);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d symbols outstanding",
                     cycles, pending_tones.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_directed();
        logic [CODE_W-1:0] list [0:15];
        list = '{12'h000, 12'hFFF, 12'h001, 12'h010, 12'h100, 12'h800,
                 12'h00F, 12'h0F0, 12'hF00, 12'hAAA, 12'h555, 12'h123,
                 12'hFED, 12'h7FF, 12'hC3A, 12'h000};
        idle_on = 1'b0;
        foreach (list[i])
            send_code(list[i]);
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (80)
            send_code(CODE_W'($urandom));
    endtask

    task automatic test_random_idle();
        logic [CODE_W-1:0] c;
        idle_on = 1'b1;
        repeat (400)
        begin
            case ($urandom_range(0, 7))
                0:       c = {CODE_W{1'b1}} ^ CODE_W'(1 << $urandom_range(0, CODE_W-1));
                1:       c = CODE_W'(1 << $urandom_range(0, CODE_W-1));
                default: c = CODE_W'($urandom);
            endcase
            send_code(c);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        code          = '0;
        idle_on       = 1'b0;
        codes_sent    = 0;
        tones_checked = 0;
        failures      = 0;
        cycles        = 0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_back_to_back();
        test_random_idle();

        @(negedge clk);
        start = 1'b0;
        while (pending_tones.size() != 0)
            @(posedge clk);
        repeat (DRAIN)
            @(posedge clk);

        $display("encoded %0d codes (directed, back-to-back, random with idle gaps)",
                 codes_sent);
        $display("checked %0d symbols, %0d mismatches", tones_checked, failures);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
